// File: rtl/core/tnv_pkg.sv
// shared types and codes for the new-note-action voice policy block
// no dependencies; every other file of the block imports this package
`default_nettype none

package tnv_pkg;

  // command codes of an event word
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_KICK = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // new-note actions
  localparam logic [1:0] NNA_CUT  = 2'd0;
  localparam logic [1:0] NNA_CONT = 2'd1;
  localparam logic [1:0] NNA_OFF  = 2'd2;
  localparam logic [1:0] NNA_FADE = 2'd3;

  // duplicate check kinds
  localparam logic [1:0] DUP_OFF    = 2'd0;
  localparam logic [1:0] DUP_NOTE   = 2'd1;
  localparam logic [1:0] DUP_SAMPLE = 2'd2;
  localparam logic [1:0] DUP_INSTR  = 2'd3;

  // duplicate actions
  localparam logic [1:0] ACT_CUT  = 2'd0;
  localparam logic [1:0] ACT_OFF  = 2'd1;
  localparam logic [1:0] ACT_FADE = 2'd2;

  // bit positions in end flags and envelope bits
  localparam int END_OFF_BIT    = 0;
  localparam int END_FADE_BIT   = 1;
  localparam int ENV_ACTIVE_BIT = 0;
  localparam int ENV_LOOPS_BIT  = 1;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_INSTRUMENTS_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOICES_IN_USE  = 2'd1;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] voice_slot;
    logic [5:0] channel_num;
    logic [7:0] instrument_id;
    logic [6:0] note_value;
    logic [7:0] sample_id;
    logic [1:0] nna_kind;
    logic       vol_env_active;
    logic       vol_env_loops;
    logic [1:0] dup_check_kind;
    logic [1:0] dup_check_action;
  } in_word_t;

  typedef struct packed {
    logic       voice_valid;
    logic [4:0] voice_index;
    logic       end_note_off;
    logic       end_note_fade;
    logic       cut_now;
    logic       detached;
    logic       carry_maybe;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       active;
    logic       has_owner;
    logic [5:0] owner;
    logic [7:0] instrument;
    logic [6:0] note;
    logic [7:0] sample;
    logic [1:0] nna;
    logic [1:0] env_bits;
    logic [1:0] end_flags;
  } voice_t;

  // write request into the voice store
  typedef struct packed {
    logic   we;
    voice_t data;
  } vs_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK_RD,
    ST_LINK_WR,
    ST_SLAVE_RD,
    ST_SLAVE,
    ST_SCAN_PRIME,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/tnv_in_if.sv
// event channel: valid/ready handshake carrying one event word
// depends on tnv_pkg for the word type
`default_nettype none

interface tnv_in_if import tnv_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tnv_out_if.sv
// report channel: valid/ready handshake carrying one report word
// depends on tnv_pkg for the word type
`default_nettype none

interface tnv_out_if import tnv_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tnv_cfg_if.sv
// configuration write channel: register index and write data
// depends on tnv_pkg for the field widths
`default_nettype none

interface tnv_cfg_if import tnv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tnv_voice_store.sv
// voice table: synchronous memory with one read and one write port
// per-entry written bits make unwritten entries read as the reset value; uses tnv_pkg
`default_nettype none

module tnv_voice_store import tnv_pkg::*; #(
  parameter int VOICES = 32,
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [VW-1:0] rd_addr,
  input  logic [VW-1:0] wr_addr,
  input  vs_wr_t        wr,
  output voice_t        rd_data
);

  voice_t            mem [VOICES];
  voice_t            rd_q;
  logic [VOICES-1:0] written;
  logic              rd_ok;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr.we) begin
        written[wr_addr] <= 1'b1;
      end
      rd_ok <= written[rd_addr];
    end
  end

  // never-written entry: inactive, ownerless, no end flags
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

// File: rtl/core/tracker_new_note_action_voice_policy.sv
// new-note-action and duplicate-check voice policy, top level
// uses tnv_pkg, the three channel interfaces and tnv_voice_store
`default_nettype none

// Usage
//   events : one word per command. load binds a voice to a channel and links
//            the channel to it, end frees a voice, kick applies the new-note
//            action of the channel's slave voice and runs the duplicate check.
//   reports: one word per voice touched by a kick, slave voice first, then
//            duplicate hits in voice order; the final word of a kick has last
//            set. loads, ends and kicks that touch nothing send no word.
//   cfg    : register writes (instruments_on, voices_in_use), always ready;
//            write only while no event is in flight.
// Timing
//   one event at a time; events.ready is high only while idle.
//   load / end: voice read, channel-link read, then write back.
//   kick: the scan covers N = min(voices_in_use, VOICES) entries; it reads one
//   voice-table entry per cycle, unless held, through the single read port and
//   writes each hit back on the write port. ignored events are dropped in idle.
//   a report waits in an output register while the next hit waits in a
//   pending register; when both are full and the receiver stalls, the scan
//   holds on the current hit and resumes when the output register drains.
// Reset
//   synchronous rst empties all voices and channel links, restores
//   instruments_on = 1 and voices_in_use = 32; no clearing pass is needed.

module tracker_new_note_action_voice_policy import tnv_pkg::*; #(
  parameter int VOICES   = 32,
  parameter int CHANNELS = 64
) (
  input  logic      clk,
  input  logic      rst,
  tnv_cfg_if.sink   cfg,
  tnv_in_if.sink    events,
  tnv_out_if.source reports
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic       instruments_on;
  logic [5:0] voices_in_use;

  // sequencer state and the event word in flight
  state_t   state;
  state_t   state_next;
  in_word_t cur;
  voice_t   ent_q;

  // channel links: slave index in memory, valid bit per channel in flops
  logic [VW-1:0]       slave_mem [CHANNELS];
  logic [VW-1:0]       slave_q;
  logic [CHANNELS-1:0] link_valid;
  logic                ch_re;
  logic                ch_we;
  logic [CW-1:0]       ch_rd_addr;
  logic [CW-1:0]       ch_wr_addr;
  logic [VW-1:0]       ch_wr_data;
  logic                link_clr;
  logic [CW-1:0]       link_clr_addr;
  logic                link_set;

  // voice store ports
  logic [VW-1:0] vs_rd_addr;
  logic [VW-1:0] vs_wr_addr;
  vs_wr_t        vs_wr;
  voice_t        vdata;

  // kick bookkeeping
  logic          carry_q;
  logic          det_ok_q;
  logic [VW-1:0] det_idx_q;
  logic          slave_take;
  logic          slave_carry;
  logic          slave_det;
  logic [1:0]    slave_flags;
  logic [VW-1:0] scan_idx;
  logic          scan_start;
  logic          scan_adv;
  logic [6:0]    scan_cnt;
  logic          scan_end;
  logic          scan_needed;
  logic          scan_match;
  logic          scan_hit;
  logic          scan_cut;
  logic [1:0]    scan_flags;
  logic          ent_take;

  // pending report and output register
  logic      pend_valid;
  out_word_t pend;
  logic      pend_load;
  out_word_t res_new;
  logic      out_valid;
  out_word_t out_word;
  logic      out_push;
  logic      push_last;
  logic      out_free;

  // index views
  logic [CW-1:0] cur_ch;
  logic [VW-1:0] slot_idx;
  logic [CW-1:0] own_addr;
  logic          in_slot_ok;
  logic          in_ch_ok;
  logic          accept;

  function automatic logic [1:0] off_flags(logic [1:0] flags, logic env_active,
                                           logic loops);
    logic [1:0] f;
    f = flags;
    f[END_OFF_BIT] = 1'b1;
    if (!env_active || loops) begin
      f[END_FADE_BIT] = 1'b1;
    end
    return f;
  endfunction

  function automatic out_word_t mk_res(logic [VW-1:0] idx, logic [1:0] flags,
                                       logic cut, logic det, logic carry);
    out_word_t r;
    r.voice_valid   = 1'b1;
    r.voice_index   = 5'(idx);
    r.end_note_off  = flags[END_OFF_BIT];
    r.end_note_fade = flags[END_FADE_BIT];
    r.cut_now       = cut;
    r.detached      = det;
    r.carry_maybe   = carry;
    r.last          = 1'b0;
    return r;
  endfunction

  tnv_voice_store #(
    .VOICES(VOICES)
  ) u_voice_store (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(vs_rd_addr),
    .wr_addr(vs_wr_addr),
    .wr     (vs_wr),
    .rd_data(vdata)
  );

  assign cur_ch     = CW'(cur.channel_num);
  assign slot_idx   = VW'(cur.voice_slot);
  assign own_addr   = CW'(ent_q.owner);
  assign in_slot_ok = 7'(events.data.voice_slot) < 7'(VOICES);
  assign in_ch_ok   = 7'(events.data.channel_num) < 7'(CHANNELS);
  assign accept     = events.valid && events.ready;

  assign scan_cnt    = (7'(voices_in_use) < 7'(VOICES)) ? 7'(voices_in_use) : 7'(VOICES);
  assign scan_end    = 7'(scan_idx) == (scan_cnt - 7'd1);
  assign scan_needed = (cur.dup_check_kind != DUP_OFF) && (scan_cnt != 7'd0);

  assign out_free = !out_valid || reports.ready;

  // slave step: new-note action of the channel's current voice
  always_comb begin
    slave_carry = vdata.instrument == cur.instrument_id;
    slave_det   = vdata.nna != NNA_CUT;
    slave_flags = vdata.end_flags;
    unique case (vdata.nna)
      NNA_OFF:  slave_flags = off_flags(vdata.end_flags, vdata.env_bits[ENV_ACTIVE_BIT],
                                        vdata.env_bits[ENV_LOOPS_BIT]);
      NNA_FADE: slave_flags[END_FADE_BIT] = 1'b1;
      NNA_CUT,
      NNA_CONT: slave_flags = vdata.end_flags;
    endcase
  end

  // duplicate check on the entry read for scan_idx
  always_comb begin
    unique case (cur.dup_check_kind)
      DUP_NOTE:   scan_hit = vdata.note == cur.note_value;
      DUP_SAMPLE: scan_hit = vdata.sample == cur.sample_id;
      DUP_INSTR:  scan_hit = 1'b1;
      DUP_OFF:    scan_hit = 1'b0;
    endcase
    // owner compare holds even after a detach
    scan_match = vdata.active && (vdata.owner == cur.channel_num) &&
                 (vdata.instrument == cur.instrument_id) && scan_hit;
    scan_cut   = 1'b0;
    scan_flags = vdata.end_flags;
    unique case (cur.dup_check_action)
      ACT_CUT:  scan_cut = 1'b1;
      ACT_OFF:  scan_flags = off_flags(vdata.end_flags, vdata.env_bits[ENV_ACTIVE_BIT],
                                       cur.vol_env_loops);
      ACT_FADE: scan_flags[END_FADE_BIT] = 1'b1;
      default:  scan_cut = 1'b0;
    endcase
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next    = state;
    vs_rd_addr    = VW'(events.data.voice_slot);
    vs_wr_addr    = slot_idx;
    vs_wr.we      = 1'b0;
    vs_wr.data    = vdata;
    ch_re         = 1'b0;
    ch_rd_addr    = CW'(events.data.channel_num);
    ch_we         = 1'b0;
    ch_wr_addr    = cur_ch;
    ch_wr_data    = slot_idx;
    link_clr      = 1'b0;
    link_clr_addr = cur_ch;
    link_set      = 1'b0;
    pend_load     = 1'b0;
    res_new       = pend;
    out_push      = 1'b0;
    push_last     = 1'b0;
    scan_start    = 1'b0;
    scan_adv      = 1'b0;
    slave_take    = 1'b0;
    ent_take      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        // read voice slot and channel link speculatively for the next event
        ch_re = 1'b1;
        if (events.valid) begin
          unique case (events.data.command)
            CMD_LOAD: if (in_slot_ok && in_ch_ok) state_next = ST_LINK_RD;
            CMD_END:  if (in_slot_ok) state_next = ST_LINK_RD;
            CMD_KICK: if (in_ch_ok && instruments_on) state_next = ST_SLAVE_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end

      ST_LINK_RD: begin
        // only the voice's owner can link to it
        ent_take   = 1'b1;
        ch_re      = 1'b1;
        ch_rd_addr = CW'(vdata.owner);
        state_next = ST_LINK_WR;
      end

      ST_LINK_WR: begin
        if (link_valid[own_addr] && (slave_q == slot_idx)) begin
          link_clr      = 1'b1;
          link_clr_addr = own_addr;
        end
        vs_wr.we   = 1'b1;
        vs_wr_addr = slot_idx;
        if (cur.command == CMD_LOAD) begin
          vs_wr.data.active     = 1'b1;
          vs_wr.data.has_owner  = 1'b1;
          vs_wr.data.owner      = cur.channel_num;
          vs_wr.data.instrument = cur.instrument_id;
          vs_wr.data.note       = cur.note_value;
          vs_wr.data.sample     = cur.sample_id;
          vs_wr.data.nna        = cur.nna_kind;
          vs_wr.data.env_bits   = {cur.vol_env_loops, cur.vol_env_active};
          vs_wr.data.end_flags  = 2'b00;
          ch_we                 = 1'b1;
          link_set              = 1'b1;
        end else begin
          vs_wr.data           = ent_q;
          vs_wr.data.active    = 1'b0;
          vs_wr.data.has_owner = 1'b0;
        end
        state_next = ST_IDLE;
      end

      ST_SLAVE_RD: begin
        if (link_valid[cur_ch]) begin
          vs_rd_addr = slave_q;
          state_next = ST_SLAVE;
        end else begin
          state_next = scan_needed ? ST_SCAN_PRIME : ST_FINISH;
        end
      end

      ST_SLAVE: begin
        slave_take = 1'b1;
        vs_wr.we   = 1'b1;
        vs_wr_addr = slave_q;
        vs_wr.data.end_flags = slave_flags;
        if (slave_det) begin
          vs_wr.data.has_owner = 1'b0;
          link_clr             = 1'b1;
          link_clr_addr        = cur_ch;
        end
        pend_load  = 1'b1;
        res_new    = mk_res(slave_q, slave_flags, 1'b0, slave_det, slave_carry);
        state_next = scan_needed ? ST_SCAN_PRIME : ST_FINISH;
      end

      ST_SCAN_PRIME: begin
        vs_rd_addr = '0;
        scan_start = 1'b1;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        if (scan_match && pend_valid && !out_free) begin
          // both report registers full: hold and reread this entry
          vs_rd_addr = scan_idx;
        end else begin
          scan_adv = 1'b1;
          if (scan_match) begin
            vs_wr.we             = 1'b1;
            vs_wr_addr           = scan_idx;
            vs_wr.data.end_flags = scan_flags;
            pend_load            = 1'b1;
            res_new              = mk_res(scan_idx, scan_flags, scan_cut,
                                          det_ok_q && (det_idx_q == scan_idx), carry_q);
            out_push             = pend_valid;
          end
          if (scan_end) begin
            vs_rd_addr = scan_idx;
            state_next = ST_FINISH;
          end else begin
            vs_rd_addr = scan_idx + VW'(1);
          end
        end
      end

      ST_FINISH: begin
        if (pend_valid) begin
          if (out_free) begin
            out_push   = 1'b1;
            push_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      instruments_on <= 1'b1;
      voices_in_use  <= 6'd32;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_INSTRUMENTS_ON: instruments_on <= cfg.data[0];
        REG_VOICES_IN_USE:  voices_in_use  <= cfg.data;
        default:            instruments_on <= instruments_on;
      endcase
    end
  end

  // channel link memory
  always_ff @(posedge clk) begin
    if (ch_we) begin
      slave_mem[ch_wr_addr] <= ch_wr_data;
    end
    if (ch_re) begin
      slave_q <= slave_mem[ch_rd_addr];
    end
  end

  // link valid bits: clear before set so a reload by the owner keeps its link
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else begin
      if (link_clr) begin
        link_valid[link_clr_addr] <= 1'b0;
      end
      if (link_set) begin
        link_valid[cur_ch] <= 1'b1;
      end
    end
  end

  // event word and kick bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= events.data;
      carry_q  <= 1'b0;
      det_ok_q <= 1'b0;
    end
    if (slave_take) begin
      carry_q   <= slave_carry;
      det_ok_q  <= slave_det;
      det_idx_q <= slave_q;
    end
    if (ent_take) begin
      ent_q <= vdata;
    end
    if (scan_start) begin
      scan_idx <= '0;
    end else if (scan_adv && !scan_end) begin
      scan_idx <= scan_idx + VW'(1);
    end
  end

  // pending report and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (out_push) begin
        pend_valid <= 1'b0;
      end
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (reports.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend <= res_new;
    end
    if (out_push) begin
      out_word      <= pend;
      out_word.last <= push_last;
    end
  end

  assign events.ready  = state == ST_IDLE;
  assign cfg.ready     = 1'b1;
  assign reports.valid = out_valid;
  assign reports.data  = out_word;

  // a kick always flushes its pending report before the next event
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending report left over at idle");

  // scan never runs past the voices in use
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (7'(scan_idx) < scan_cnt))
    else $error("scan index out of range");

  // a load always leaves the loading channel linked
  a_load_links: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LINK_WR) && (cur.command == CMD_LOAD)) |=> link_valid[cur_ch])
    else $error("load did not link its channel");

endmodule

`default_nettype wire
